// File: rtl/jmdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmdr_pkg: shared types and constants
// Widths, command codes, controller states and the control/status structs
// shared by the jet/muon delta-R overlap filter modules.
// ----------------------------------------------------------------------------
package jmdr_pkg;

	// field widths
	localparam int ETA_W  = 13;
	localparam int PHI_W  = 12;
	localparam int DIST_W = 24;
	localparam int CMD_W  = 2;

	// |deta| <= 8191, |dphi| <= 2048, squares and their sum
	localparam int AETA_W = ETA_W;
	localparam int APHI_W = PHI_W;
	localparam int ESQ_W  = 2 * AETA_W;
	localparam int PSQ_W  = 2 * APHI_W;
	localparam int SUM_W  = ESQ_W + 1;

	// threshold after reset: 652^2
	localparam logic [DIST_W-1:0] MIN_DIST_RESET = 24'd425104;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_TEST  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic signed [ETA_W-1:0] eta;
		logic [PHI_W-1:0]        phi;
	} muon_t;

	localparam int MUON_W = $bits(muon_t);

	// controller -> datapath
	typedef struct packed {
		logic clear_store;
		logic load_pair;
		logic start_jet;
		logic issue;
		logic write_result;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_busy;
		logic store_full;
		logic store_empty;
	} dp_stat_t;

endpackage

// File: rtl/jmdr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmdr_if: channel interfaces
// Valid/ready channels for input words, result words and threshold writes.
// ----------------------------------------------------------------------------

// input word: command plus jet or muon-pair coordinates
interface jmdr_in_if import jmdr_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic signed [ETA_W-1:0] first_eta;
	logic [PHI_W-1:0]        first_phi;
	logic signed [ETA_W-1:0] second_eta;
	logic [PHI_W-1:0]        second_phi;

	modport source (
		output valid, command, first_eta, first_phi, second_eta, second_phi,
		input  ready
	);
	modport sink (
		input  valid, command, first_eta, first_phi, second_eta, second_phi,
		output ready
	);
endinterface

// result word: one per jet test
interface jmdr_out_if ();
	logic valid;
	logic ready;
	logic keep_jet;
	logic store_overflow;

	modport source (
		output valid, keep_jet, store_overflow,
		input  ready
	);
	modport sink (
		input  valid, keep_jet, store_overflow,
		output ready
	);
endinterface

// threshold register write
interface jmdr_cfg_if import jmdr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] min_distance_sq;

	modport source (
		output valid, min_distance_sq,
		input  ready
	);
	modport sink (
		input  valid, min_distance_sq,
		output ready
	);
endinterface

// File: rtl/jmdr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmdr_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle, read data registered, no reset.
// ----------------------------------------------------------------------------
module jmdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/jmdr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmdr_datapath: muon store and distance pipeline
// Holds the threshold, pair count and overflow flag, the muon-pair RAM and
// a four-stage squared-distance comparator shared by all muons of a scan.
// ----------------------------------------------------------------------------
module jmdr_datapath import jmdr_pkg::*; #(
	parameter int MAX_PAIRS = 8,
	localparam int AW       = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1,
	localparam int CNTW     = $clog2(MAX_PAIRS + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctrl_cmd_t               cmd,
	input  logic [AW-1:0]           rd_row,
	input  logic                    rd_half,
	input  logic                    cfg_wr,
	input  logic [DIST_W-1:0]       cfg_data,
	input  logic signed [ETA_W-1:0] first_eta,
	input  logic [PHI_W-1:0]        first_phi,
	input  logic signed [ETA_W-1:0] second_eta,
	input  logic [PHI_W-1:0]        second_phi,
	output logic [CNTW-1:0]         pair_count,
	output dp_stat_t                stat,
	output logic                    keep_jet,
	output logic                    store_overflow
);

	logic [DIST_W-1:0]       thr_q;
	logic [CNTW-1:0]         count_q;
	logic                    ovf_q;
	logic                    full;
	logic signed [ETA_W-1:0] jet_eta_q;
	logic [PHI_W-1:0]        jet_phi_q;
	logic                    hit_q;
	logic [2*MUON_W-1:0]     ram_wdata;
	logic [2*MUON_W-1:0]     ram_rdata;
	logic                    v_s1, v_s2, v_s3;
	logic                    half_s1;
	muon_t                   muon_sel;
	logic signed [ETA_W:0]   deta;
	logic [ETA_W:0]          deta_abs;
	logic [PHI_W-1:0]        dphi;
	logic [AETA_W-1:0]       ae_s2;
	logic [APHI_W-1:0]       ap_s2;
	logic [ESQ_W-1:0]        esq_s3;
	logic [PSQ_W-1:0]        psq_s3;
	logic [SUM_W-1:0]        dist_sum;
	logic                    keep_q;
	logic                    ovfo_q;

	assign full = (count_q == CNTW'(MAX_PAIRS));

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= MIN_DIST_RESET;
		end else if (cfg_wr) begin
			thr_q <= cfg_data;
		end
	end

	// pair count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.clear_store) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.load_pair) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				count_q <= count_q + CNTW'(1);
			end
		end
	end

	// one row per pair: first muon in the upper half, second in the lower
	assign ram_wdata = {first_eta, first_phi, second_eta, second_phi};

	jmdr_ram #(
		.WIDTH (2 * MUON_W),
		.DEPTH (MAX_PAIRS)
	) u_store (
		.clk   (clk),
		.we    (cmd.load_pair && !full),
		.waddr (count_q[AW-1:0]),
		.wdata (ram_wdata),
		.raddr (rd_row),
		.rdata (ram_rdata)
	);

	// jet coordinates, held for the scan
	always_ff @(posedge clk) begin
		if (cmd.start_jet) begin
			jet_eta_q <= first_eta;
			jet_phi_q <= first_phi;
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1 aligns with RAM read data
	always_ff @(posedge clk) begin
		half_s1 <= rd_half;
	end

	// stage 2: pick the muon, signed eta difference, wrapped phi difference
	always_comb begin
		muon_sel = half_s1 ? muon_t'(ram_rdata[MUON_W-1:0])
		                   : muon_t'(ram_rdata[2*MUON_W-1:MUON_W]);
		deta     = (ETA_W+1)'(jet_eta_q) - (ETA_W+1)'(muon_sel.eta);
		deta_abs = deta[ETA_W] ? (ETA_W+1)'(-deta) : (ETA_W+1)'(deta);
		dphi     = jet_phi_q - muon_sel.phi;
	end

	always_ff @(posedge clk) begin
		ae_s2 <= deta_abs[AETA_W-1:0];
		ap_s2 <= dphi[PHI_W-1] ? (PHI_W'(0) - dphi) : dphi;
	end

	// stage 3: squares
	always_ff @(posedge clk) begin
		esq_s3 <= ESQ_W'(ae_s2) * ESQ_W'(ae_s2);
		psq_s3 <= PSQ_W'(ap_s2) * PSQ_W'(ap_s2);
	end

	// stage 4: sum and compare, sticky hit for the current jet
	assign dist_sum = SUM_W'(esq_s3) + SUM_W'(psq_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.start_jet) begin
			hit_q <= 1'b0;
		end else if (v_s3 && (dist_sum < SUM_W'(thr_q))) begin
			hit_q <= 1'b1;
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (cmd.write_result) begin
			keep_q <= !hit_q;
			ovfo_q <= ovf_q;
		end
	end

	assign pair_count        = count_q;
	assign stat.pipe_busy    = v_s1 | v_s2 | v_s3;
	assign stat.store_full   = full;
	assign stat.store_empty  = (count_q == '0);
	assign keep_jet          = keep_q;
	assign store_overflow    = ovfo_q;

endmodule

// File: rtl/jmdr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jmdr_ctrl: command sequencer
// Decodes input words, walks the stored muons one per cycle for a jet test,
// waits for the distance pipeline to drain and hands off the result word.
// ----------------------------------------------------------------------------
module jmdr_ctrl import jmdr_pkg::*; #(
	parameter int MAX_PAIRS = 8,
	localparam int AW       = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1,
	localparam int CNTW     = $clog2(MAX_PAIRS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_command,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  logic [CNTW-1:0]  pair_count,
	input  dp_stat_t         stat,
	output ctrl_cmd_t        cmd,
	output logic [AW-1:0]    rd_row,
	output logic             rd_half
);

	state_t        state_q, state_d;
	logic [AW-1:0] row_q;
	logic          half_q;
	logic          out_valid_q;
	logic          accept;
	logic          last;
	logic          slot_free;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign last      = half_q && ((CNTW'(row_q) + CNTW'(1)) == pair_count);
	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_command == CMD_TEST)) begin
					state_d = stat.store_empty ? ST_REPORT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_REPORT;
				end
			end
			ST_REPORT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready         = (state_q == ST_IDLE);
		cmd.clear_store  = accept && (in_command == CMD_CLEAR);
		cmd.load_pair    = accept && (in_command == CMD_LOAD);
		cmd.start_jet    = accept && (in_command == CMD_TEST);
		cmd.issue        = (state_q == ST_SCAN);
		cmd.write_result = (state_q == ST_REPORT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// muon walk: two muons per stored row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			half_q <= 1'b0;
		end else if (cmd.start_jet) begin
			row_q  <= '0;
			half_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			half_q <= !half_q;
			if (half_q) begin
				row_q <= row_q + AW'(1);
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.write_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign rd_row    = row_q;
	assign rd_half   = half_q;

endmodule

// File: rtl/jet_muon_delta_r_overlap_filter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jet_muon_delta_r_overlap_filter_unit: jet/muon delta-R overlap filter
// Stores muon pairs per event and flags jets that lie within the squared
// eta-phi threshold of any stored muon.
// ----------------------------------------------------------------------------
//  channel     dir  handshake       word
//  jet_in      in   valid/ready     command, first/second eta and phi
//  result_out  out  valid/ready     keep_jet, store_overflow
//  cfg         in   valid/ready     min_distance_sq (always ready)
//
// Clear and load words are taken straight from idle. A jet test with N stored
// pairs sends one muon per cycle through the shared distance pipeline, waits
// in the drain state until the pipeline is empty, hands off the result word
// and returns to idle; with no stored pairs it goes straight to the hand-off.
// Reset clears the pair count and overflow flag and restores the threshold
// to 652^2; the store RAM is not cleared. A stalled result word holds in its
// register; the next input word is taken meanwhile and only a jet result
// waits for the slot.
// ----------------------------------------------------------------------------
module jet_muon_delta_r_overlap_filter_unit import jmdr_pkg::*; #(
	parameter int MAX_PAIRS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	jmdr_in_if.sink       jet_in,
	jmdr_out_if.source    result_out,
	jmdr_cfg_if.sink      cfg
);

	localparam int AW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
	localparam int CNTW = $clog2(MAX_PAIRS + 1);

	ctrl_cmd_t       dp_cmd;
	dp_stat_t        stat;
	logic [AW-1:0]   rd_row;
	logic            rd_half;
	logic [CNTW-1:0] pair_count;

	// threshold writes are always taken
	assign cfg.ready = 1'b1;

	jmdr_ctrl #(
		.MAX_PAIRS (MAX_PAIRS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (jet_in.valid),
		.in_command (jet_in.command),
		.in_ready   (jet_in.ready),
		.out_valid  (result_out.valid),
		.out_ready  (result_out.ready),
		.pair_count (pair_count),
		.stat       (stat),
		.cmd        (dp_cmd),
		.rd_row     (rd_row),
		.rd_half    (rd_half)
	);

	jmdr_datapath #(
		.MAX_PAIRS (MAX_PAIRS)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.rd_row         (rd_row),
		.rd_half        (rd_half),
		.cfg_wr         (cfg.valid),
		.cfg_data       (cfg.min_distance_sq),
		.first_eta      (jet_in.first_eta),
		.first_phi      (jet_in.first_phi),
		.second_eta     (jet_in.second_eta),
		.second_phi     (jet_in.second_phi),
		.pair_count     (pair_count),
		.stat           (stat),
		.keep_jet       (result_out.keep_jet),
		.store_overflow (result_out.store_overflow)
	);

`ifndef SYNTHESIS
	// pair count never passes the store size
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pair_count <= CNTW'(MAX_PAIRS))
		else $error("pair count above store size");

	// a load into a full store leaves the count alone
	a_full_load: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.load_pair && stat.store_full) |=> $stable(pair_count))
		else $error("load into full store changed pair count");

	// scan reads only rows that were loaded
	a_issue_row: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.issue |-> (CNTW'(rd_row) < pair_count))
		else $error("scan read beyond loaded rows");

	// new words only enter with the distance pipeline empty
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		jet_in.ready |-> !stat.pipe_busy)
		else $error("input taken while distance pipeline busy");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: jet/muon delta-R overlap filter unit
// Drives event words (clear, muon-pair load, jet test) with random gaps and
// back-pressure, predicts each jet's keep and overflow flags from its own
// copy of the muon store and threshold, and checks every result word in
// order. The threshold is rewritten between phases, including both extremes.
// ----------------------------------------------------------------------------
module testbench;
	import jmdr_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int PAIR_CAP      = 8;
	localparam int SETTLE_CYCLES = 4 * PAIR_CAP + 10;
	localparam int TIMEOUT_NS    = 10_000_000;

	// command code the block ignores
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]        command;
		logic signed [ETA_W-1:0] first_eta;
		logic [PHI_W-1:0]        first_phi;
		logic signed [ETA_W-1:0] second_eta;
		logic [PHI_W-1:0]        second_phi;
	} in_word_t;

	typedef struct {
		logic keep;
		logic overflow;
	} verdict_t;

	// muon store mirror, threshold, and queue of jet verdicts still to arrive
	class jet_verdict_board;
		logic [DIST_W-1:0]       threshold;
		logic signed [ETA_W-1:0] muon_eta [2*PAIR_CAP];
		logic [PHI_W-1:0]        muon_phi [2*PAIR_CAP];
		int unsigned             pairs;
		logic                    overflow;
		verdict_t                pending [$];
		int                      errors;

		function new();
			threshold = MIN_DIST_RESET;
			pairs     = 0;
			overflow  = 1'b0;
			errors    = 0;
		endfunction

		task report(input string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// squared eta-phi distance, phi difference wrapped to [-2048, 2047]
		function int unsigned muon_distance(logic signed [ETA_W-1:0] jet_eta,
		                                    logic [PHI_W-1:0] jet_phi, int idx);
			int                      de;
			int                      dp;
			logic signed [PHI_W-1:0] wrapped;
			de      = int'(jet_eta) - int'(muon_eta[idx]);
			wrapped = jet_phi - muon_phi[idx];
			dp      = int'(wrapped);
			return de * de + dp * dp;
		endfunction

		function void note_word(in_word_t w);
			verdict_t v;
			case (w.command)
				CMD_CLEAR: begin
					pairs    = 0;
					overflow = 1'b0;
				end
				CMD_LOAD: begin
					if (pairs == PAIR_CAP) begin
						overflow = 1'b1;
					end else begin
						muon_eta[2*pairs]   = w.first_eta;
						muon_phi[2*pairs]   = w.first_phi;
						muon_eta[2*pairs+1] = w.second_eta;
						muon_phi[2*pairs+1] = w.second_phi;
						pairs++;
					end
				end
				CMD_TEST: begin
					v.keep     = 1'b1;
					v.overflow = overflow;
					for (int i = 0; i < 2 * pairs; i++)
						if (muon_distance(w.first_eta, w.first_phi, i) < threshold)
							v.keep = 1'b0;
					pending = {pending, v};
				end
				default: ;
			endcase
		endfunction

		task check_verdict(input logic keep, input logic ovf);
			verdict_t v;
			if (pending.size() == 0) begin
				report("result word with no jet test outstanding");
			end else begin
				v = pending.pop_front();
				if (keep !== v.keep)
					report($sformatf("keep_jet %b, predicted %b", keep, v.keep));
				if (ovf !== v.overflow)
					report($sformatf("store_overflow %b, predicted %b", ovf, v.overflow));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;

	jmdr_in_if  jet_in ();
	jmdr_out_if result_out ();
	jmdr_cfg_if cfg ();

	jet_muon_delta_r_overlap_filter_unit #(
		.MAX_PAIRS(PAIR_CAP)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.jet_in    (jet_in),
		.result_out(result_out),
		.cfg       (cfg)
	);

	jet_verdict_board sb = new();

	bit tx_steady;
	bit rx_steady;
	int rx_hold;
	int rx_gap_left;

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// gap length: mostly short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// offer one input word after an optional idle gap, return once accepted
	task automatic put(input logic [CMD_W-1:0] cmd, input int e1, input int p1,
	                   input int e2, input int p2);
		in_word_t w;
		int       gap;
		w.command    = cmd;
		w.first_eta  = ETA_W'(e1);
		w.first_phi  = PHI_W'(p1);
		w.second_eta = ETA_W'(e2);
		w.second_phi = PHI_W'(p2);
		gap = (!tx_steady && $urandom_range(0, 3) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			@(negedge clk);
			jet_in.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		jet_in.valid      = 1'b1;
		jet_in.command    = w.command;
		jet_in.first_eta  = w.first_eta;
		jet_in.first_phi  = w.first_phi;
		jet_in.second_eta = w.second_eta;
		jet_in.second_phi = w.second_phi;
		do @(posedge clk); while (!jet_in.ready);
		sb.note_word(w);
	endtask

	// stop offering, wait for every jet result, then let the pipeline empty
	task automatic settle();
		@(negedge clk);
		jet_in.valid = 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [DIST_W-1:0] v);
		settle();
		@(negedge clk);
		cfg.valid           = 1'b1;
		cfg.min_distance_sq = v;
		do @(posedge clk); while (!cfg.ready);
		sb.threshold = v;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// random events: clear, some loads, jets aimed near stored muons; plus noise
	task automatic run_events(input int budget);
		int sent;
		int npairs;
		int njets;
		int k;
		int reach;
		int e1;
		int p1;
		int eta_pick [$];
		int phi_pick [$];
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 9) == 0) begin
				k = $urandom_range(0, 3);
				put(CMD_W'(k), $urandom_range(0, 8191), $urandom_range(0, 4095),
				    $urandom_range(0, 8191), $urandom_range(0, 4095));
				if (k != CMD_UNUSED)
					sent++;
			end else begin
				put(CMD_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 4095),
				    $urandom_range(0, 8191), $urandom_range(0, 4095));
				sent++;
				eta_pick.delete();
				phi_pick.delete();
				npairs = ($urandom_range(0, 9) < 8) ? $urandom_range(0, PAIR_CAP)
				                                    : $urandom_range(PAIR_CAP + 1, PAIR_CAP + 3);
				for (int i = 0; i < npairs; i++) begin
					for (int m = 0; m < 2; m++) begin
						eta_pick = {eta_pick, int'($urandom_range(0, 8191)) - 4096};
						phi_pick = {phi_pick, int'($urandom_range(0, 4095))};
					end
					put(CMD_LOAD, eta_pick[2*i], phi_pick[2*i],
					    eta_pick[2*i+1], phi_pick[2*i+1]);
					sent++;
				end
				njets = $urandom_range(1, 6);
				for (int j = 0; j < njets; j++) begin
					if (eta_pick.size() != 0 && $urandom_range(0, 2) != 0) begin
						// aim at a muon, sometimes exactly on it
						k     = $urandom_range(0, eta_pick.size() - 1);
						reach = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1400);
						e1    = eta_pick[k] + int'($urandom_range(0, 2 * reach)) - reach;
						p1    = phi_pick[k] + int'($urandom_range(0, 2 * reach)) - reach;
						if (e1 > 4095)
							e1 = 4095;
						if (e1 < -4096)
							e1 = -4096;
					end else begin
						e1 = $urandom_range(0, 8191);
						p1 = $urandom_range(0, 4095);
					end
					put(CMD_TEST, e1, p1, $urandom_range(0, 8191), $urandom_range(0, 4095));
					sent++;
				end
			end
		end
	endtask

	// result sink: random back-pressure, plus a long hold-off on request
	initial begin
		result_out.ready = 1'b0;
		rx_gap_left      = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				result_out.ready = 1'b0;
				rx_hold--;
			end else if (rx_gap_left > 0) begin
				result_out.ready = 1'b0;
				rx_gap_left--;
			end else begin
				result_out.ready = 1'b1;
				if (!rx_steady && $urandom_range(0, 3) == 0)
					rx_gap_left = gap_len();
			end
		end
	end

	// check each result word as it is taken
	always @(posedge clk)
		if (arst_n && result_out.valid && result_out.ready)
			sb.check_verdict(result_out.keep_jet, result_out.store_overflow);

	initial begin
		#(TIMEOUT_NS);
		$display("[jet_muon_delta_r_overlap_filter_unit] ERROR");
		$finish;
	end

	// main sequence
	initial begin
		arst_n              = 1'b0;
		tx_steady           = 1'b0;
		rx_steady           = 1'b0;
		rx_hold             = 0;
		jet_in.valid        = 1'b0;
		jet_in.command      = CMD_CLEAR;
		jet_in.first_eta    = '0;
		jet_in.first_phi    = '0;
		jet_in.second_eta   = '0;
		jet_in.second_phi   = '0;
		cfg.valid           = 1'b0;
		cfg.min_distance_sq = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words under the reset threshold (652^2)
		put(CMD_TEST, -4096, 4095, 4095, 0);          // empty store keeps the jet
		put(CMD_CLEAR, 0, 0, 0, 0);
		put(CMD_LOAD, -4096, 0, 4095, 4095);           // field extremes
		put(CMD_TEST, 4095, 0, 0, 0);                  // phi wraps: dphi of one
		put(CMD_TEST, -3444, 0, 0, 0);                 // distance equals threshold
		put(CMD_TEST, -3445, 0, 0, 0);                 // just inside threshold
		put(CMD_TEST, 0, 2048, -1, 4095);              // second fields ignored
		put(CMD_UNUSED, 1234, 567, -890, 1011);        // ignored code
		put(CMD_TEST, -4096, 2048, -1, 4095);          // half-turn phi difference
		for (int i = 0; i < PAIR_CAP - 1; i++)
			put(CMD_LOAD, i * 500 - 1500, 1024, i * 500 - 1500, 3072);
		put(CMD_LOAD, 2000, 500, 2000, 500);           // full store: dropped
		put(CMD_TEST, 2000, 500, 0, 0);                // kept, overflow set
		put(CMD_CLEAR, 0, 0, 0, 0);
		put(CMD_TEST, 2000, 500, 0, 0);                // overflow cleared
		put(CMD_LOAD, 100, 4000, -100, 50);
		put(CMD_TEST, 100, 4000, 0, 0);                // exact coincidence

		// threshold zero: nothing is ever dropped
		write_threshold('0);
		run_events(200);

		// largest threshold, with a long result stall at the start
		write_threshold({DIST_W{1'b1}});
		@(negedge clk);
		rx_hold = 400;
		run_events(200);

		// only an exact hit drops a jet
		write_threshold(24'd1);
		run_events(200);

		// random threshold, no idling on either side
		write_threshold(DIST_W'($urandom_range(2, 24'hFFFFFE)));
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		run_events(200);
		tx_steady = 1'b0;
		rx_steady = 1'b0;

		// back to the reset value; sender pauses mid-way until all results are in
		write_threshold(MIN_DIST_RESET);
		run_events(125);
		settle();
		run_events(125);

		write_threshold(DIST_W'($urandom_range(1000, 4_000_000)));
		run_events(450);

		settle();
		if (sb.errors == 0)
			$display("[jet_muon_delta_r_overlap_filter_unit] OK");
		else
			$display("[jet_muon_delta_r_overlap_filter_unit] ERROR");
		$finish;
	end

endmodule
